[rtl/core/osm_pkg.sv]
// ============================================================================
// osm_pkg
// Shared types and constants for the order-statistic multiset unit.
// ============================================================================
`default_nettype none

package osm_pkg;

    // Default number of cells in the row (stored values).
    localparam int CAPACITY_DEF = 1024;

    // Fixed answers when nothing lies below or above.
    localparam logic signed [31:0] LOW_BOUND  = -32'sd2147483647;
    localparam logic signed [31:0] HIGH_BOUND = 32'sd2147483647;

    typedef enum logic [2:0] {
        MODE_RANK   = 3'd0,
        MODE_KTH    = 3'd1,
        MODE_PRED   = 3'd2,
        MODE_SUCC   = 3'd3,
        MODE_INSERT = 3'd4
    } mode_t;

    typedef struct packed {
        logic [2:0]         mode;
        logic signed [31:0] operand;
    } item_t;

    typedef struct packed {
        logic signed [31:0] answer;
        logic               status;
    } result_t;

    // Operation traveling down the row. For insert, key is the value
    // still looking for a home.
    typedef struct packed {
        mode_t              mode;
        logic signed [31:0] key;
        logic signed [31:0] answer;
        logic               done;
        logic               status;
    } op_t;

endpackage

`default_nettype wire

[rtl/core/osm_entry.sv]
// ============================================================================
// osm_entry
// Decodes an item into a row operation and tracks the element count.
// ============================================================================
`default_nettype none

module osm_entry #(
    parameter int CAPACITY = osm_pkg::CAPACITY_DEF,
    localparam int CW      = $clog2(CAPACITY + 1)
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          adv,
    input  wire logic          item_valid,
    input  wire osm_pkg::item_t item,
    output logic               dn_valid,
    output osm_pkg::op_t       dn_op,
    output logic [CW-1:0]      dn_left,
    output logic [CW-1:0]      dn_cnt
);

    logic              count_full;
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;
    logic              dn_valid_reg;
    osm_pkg::op_t      dn_op_reg;
    osm_pkg::op_t      dn_op_next;
    logic [CW-1:0]     dn_left_reg;
    logic [CW-1:0]     dn_cnt_reg;
    logic [CW-1:0]     dn_cnt_next;

    assign count_full = (count_reg == CW'(CAPACITY));

    always_comb
    begin
        dn_op_next.mode   = osm_pkg::MODE_RANK;
        dn_op_next.key    = item.operand;
        dn_op_next.answer = '0;
        dn_op_next.done   = 1'b1;   // unused modes pass through as no-ops
        dn_op_next.status = 1'b0;
        dn_cnt_next       = '0;
        count_next        = count_reg;
        unique case (item.mode)
            osm_pkg::MODE_RANK:
            begin
                dn_op_next.done = 1'b0;
            end
            osm_pkg::MODE_KTH:
            begin
                dn_op_next.mode = osm_pkg::MODE_KTH;
                if (item.operand <= 32'sd0)
                begin
                    dn_op_next.answer = osm_pkg::LOW_BOUND;
                end
                else if (item.operand > $signed({{(32 - CW){1'b0}}, count_reg}))
                begin
                    dn_op_next.answer = osm_pkg::HIGH_BOUND;
                end
                else
                begin
                    dn_op_next.done = 1'b0;
                    dn_cnt_next     = CW'(item.operand - 32'sd1);
                end
            end
            osm_pkg::MODE_PRED:
            begin
                dn_op_next.mode   = osm_pkg::MODE_PRED;
                dn_op_next.answer = osm_pkg::LOW_BOUND;
                dn_op_next.done   = 1'b0;
            end
            osm_pkg::MODE_SUCC:
            begin
                dn_op_next.mode   = osm_pkg::MODE_SUCC;
                dn_op_next.answer = osm_pkg::HIGH_BOUND;
                dn_op_next.done   = 1'b0;
            end
            osm_pkg::MODE_INSERT:
            begin
                dn_op_next.mode = osm_pkg::MODE_INSERT;
                if (count_full)
                begin
                    dn_op_next.status = 1'b1;
                end
                else
                begin
                    dn_op_next.done = 1'b0;
                    if (item_valid && adv)
                    begin
                        count_next = count_reg + 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            dn_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (adv)
            begin
                dn_valid_reg <= item_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dn_op_reg   <= dn_op_next;
            dn_left_reg <= count_reg;
            dn_cnt_reg  <= dn_cnt_next;
        end
    end

    assign dn_valid = dn_valid_reg;
    assign dn_op    = dn_op_reg;
    assign dn_left  = dn_left_reg;
    assign dn_cnt   = dn_cnt_reg;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("element count above capacity");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && adv && item.mode == osm_pkg::MODE_INSERT && !count_full)
        |=> count_reg == $past(count_reg) + 1'b1)
        else $error("accepted insert did not bump the count");

endmodule

`default_nettype wire

[rtl/core/osm_cell.sv]
// ============================================================================
// osm_cell
// One stored value; applies the passing operation and hands it on.
// ============================================================================
`default_nettype none

module osm_cell #(
    parameter int CAPACITY = osm_pkg::CAPACITY_DEF,
    parameter int INDEX    = 0,
    localparam int CW      = $clog2(CAPACITY + 1)
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          adv,
    input  wire logic          up_valid,
    input  wire osm_pkg::op_t  up_op,
    input  wire logic [CW-1:0] up_left,
    input  wire logic [CW-1:0] up_cnt,
    output logic               dn_valid,
    output osm_pkg::op_t       dn_op,
    output logic [CW-1:0]      dn_left,
    output logic [CW-1:0]      dn_cnt
);

    logic signed [31:0] value_reg;
    logic signed [31:0] value_next;
    logic               occ;
    logic               lt;
    logic               gt;
    logic               dn_valid_reg;
    osm_pkg::op_t       dn_op_reg;
    osm_pkg::op_t       dn_op_next;
    logic [CW-1:0]      dn_left_reg;
    logic [CW-1:0]      dn_left_next;
    logic [CW-1:0]      dn_cnt_reg;
    logic [CW-1:0]      dn_cnt_next;

    // up_left counts occupied cells from here on
    assign occ = (up_left != '0);
    assign lt  = (value_reg < up_op.key);
    assign gt  = (value_reg > up_op.key);

    always_comb
    begin
        value_next   = value_reg;
        dn_op_next   = up_op;
        dn_cnt_next  = up_cnt;
        dn_left_next = occ ? (up_left - 1'b1) : '0;
        if (up_valid && !up_op.done)
        begin
            unique case (up_op.mode)
                osm_pkg::MODE_RANK:
                begin
                    if (occ && lt)
                    begin
                        dn_cnt_next = up_cnt + 1'b1;
                    end
                end
                osm_pkg::MODE_KTH:
                begin
                    if (occ && up_cnt == CW'(INDEX))
                    begin
                        dn_op_next.answer = value_reg;
                        dn_op_next.done   = 1'b1;
                    end
                end
                osm_pkg::MODE_PRED:
                begin
                    if (occ && lt)
                    begin
                        dn_op_next.answer = value_reg;
                    end
                end
                osm_pkg::MODE_SUCC:
                begin
                    if (occ && gt)
                    begin
                        dn_op_next.answer = value_reg;
                        dn_op_next.done   = 1'b1;
                    end
                end
                osm_pkg::MODE_INSERT:
                begin
                    // keep the smaller, pass the larger; empty cell takes it
                    if (!occ)
                    begin
                        value_next      = up_op.key;
                        dn_op_next.done = 1'b1;
                    end
                    else if (gt)
                    begin
                        value_next     = up_op.key;
                        dn_op_next.key = value_reg;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dn_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            dn_valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            value_reg   <= value_next;
            dn_op_reg   <= dn_op_next;
            dn_left_reg <= dn_left_next;
            dn_cnt_reg  <= dn_cnt_next;
        end
    end

    assign dn_valid = dn_valid_reg;
    assign dn_op    = dn_op_reg;
    assign dn_left  = dn_left_reg;
    assign dn_cnt   = dn_cnt_reg;

endmodule

`default_nettype wire

[rtl/core/order_statistic_multiset_unit.sv]
// ============================================================================
// order_statistic_multiset_unit
// Sorted multiset of signed 32-bit values held in a row of compare cells;
// answers rank, k-th smallest, predecessor and successor, and inserts.
// ============================================================================
//
//   Channel   Handshake                    Payload
//   -------   --------------------------   ---------------------------------
//   item      item_valid / item_ready      osm_pkg::item_t   {mode, operand}
//   result    result_valid / result_ready  osm_pkg::result_t {answer, status}
//
// One item enters per cycle while the result is not stalled; it passes the
// entry register, one register per cell and the output register before its
// result appears. Each operation visits every cell of the row in turn.
// Reset clears the element count and every stage valid; stored values are
// not cleared, since the count marks which cells hold data.
// A stalled result freezes the whole row, and item_ready drops with it.
//
// Operations move down the row in order, one cell per cycle unless stalled,
// so a later operation always sees a cell after every earlier one was there.
// ============================================================================
`default_nettype none

module order_statistic_multiset_unit #(
    parameter int CAPACITY = osm_pkg::CAPACITY_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             item_valid,
    output logic                  item_ready,
    input  wire osm_pkg::item_t   item,
    output logic                  result_valid,
    input  wire logic             result_ready,
    output osm_pkg::result_t      result
);

    localparam int CW = $clog2(CAPACITY + 1);

    // Stage s feeds cell s; stage CAPACITY feeds the output register.
    logic          slot_valid [0:CAPACITY];
    osm_pkg::op_t  slot_op    [0:CAPACITY];
    logic [CW-1:0] slot_left  [0:CAPACITY];
    logic [CW-1:0] slot_cnt   [0:CAPACITY];

    logic             adv;
    logic             result_valid_reg;
    osm_pkg::result_t result_reg;
    osm_pkg::result_t result_next;
    logic [CW:0]      rank;

    // Whole row moves together whenever the output register can take a slot.
    assign adv        = !result_valid_reg || result_ready;
    assign item_ready = adv;

    osm_entry #(
        .CAPACITY (CAPACITY)
    ) u_entry (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .item_valid (item_valid),
        .item       (item),
        .dn_valid   (slot_valid[0]),
        .dn_op      (slot_op[0]),
        .dn_left    (slot_left[0]),
        .dn_cnt     (slot_cnt[0])
    );

    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        osm_cell #(
            .CAPACITY (CAPACITY),
            .INDEX    (g)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .adv      (adv),
            .up_valid (slot_valid[g]),
            .up_op    (slot_op[g]),
            .up_left  (slot_left[g]),
            .up_cnt   (slot_cnt[g]),
            .dn_valid (slot_valid[g+1]),
            .dn_op    (slot_op[g+1]),
            .dn_left  (slot_left[g+1]),
            .dn_cnt   (slot_cnt[g+1])
        );
    end

    // Rank is one more than the number of cells below the key.
    assign rank = {1'b0, slot_cnt[CAPACITY]} + 1'b1;

    always_comb
    begin
        result_next.status = slot_op[CAPACITY].status;
        if (slot_op[CAPACITY].mode == osm_pkg::MODE_RANK && !slot_op[CAPACITY].done)
        begin
            result_next.answer = $signed(32'(rank));
        end
        else
        begin
            result_next.answer = slot_op[CAPACITY].answer;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            result_valid_reg <= slot_valid[CAPACITY];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // A stall must freeze the end of the row, not just the output register.
    a_row_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(slot_valid[CAPACITY]) && $stable(slot_op[CAPACITY]))
        else $error("row advanced during a stall");

    // An accepted insert must find a free cell before leaving the row.
    a_insert_placed: assert property (@(posedge clk) disable iff (!rst_n)
        (slot_valid[CAPACITY] && slot_op[CAPACITY].mode == osm_pkg::MODE_INSERT
         && !slot_op[CAPACITY].status) |-> slot_op[CAPACITY].done)
        else $error("insert left the row unplaced");

    a_drop_answer: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && result_reg.status) |-> result_reg.answer == '0)
        else $error("dropped insert carries a nonzero answer");

endmodule

`default_nettype wire
